@@ hdl/sfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, sizes and the rounding helper function of the stereo FIR convolver.
// ----------------------------------------------------------------------------
package sfc_pkg;

    // Sizing
    localparam int MAX_TAPS    = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int ADDR_W      = $clog2(MAX_TAPS);
    localparam int CNT_W       = $clog2(MAX_TAPS + 1);
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int ACC_W       = PROD_W + ADDR_W + 1;

    // Fixed field widths
    localparam int REQ_W       = 2;
    localparam int IDX_W       = 12;
    localparam int TAP_CFG_W   = 13;
    localparam int CHAN_CFG_W  = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    // Rounding and saturation
    localparam int HALF_LSB    = 2 ** (FRAC_BITS - 1);
    localparam int SAT_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAT_MIN     = -(2 ** (SAMPLE_BITS - 1));

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_FRAME = 2'd0,
        REQ_COEFF = 2'd1,
        REQ_CLEAR = 2'd2
    } req_kind_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_ROUND
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic frame_start;
        logic tap_issue;
        logic coeff_wr;
        logic hist_clear;
        logic result_load;
    } sfc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_tap;
        logic pipe_idle;
        logic out_free;
    } sfc_sts_t;

    // Round to nearest (ties up) from Q.2F to Q1.F, then saturate.
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] shifted;
        logic signed [SAMPLE_BITS-1:0] res;
        biased  = acc + ACC_W'(HALF_LSB);
        shifted = biased >>> FRAC_BITS;
        if (shifted > ACC_W'(SAT_MAX)) begin
            res = SAMPLE_BITS'(SAT_MAX);
        end else if (shifted < ACC_W'(SAT_MIN)) begin
            res = SAMPLE_BITS'(SAT_MIN);
        end else begin
            res = shifted[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ hdl/sfc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ hdl/sfc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_ctrl
// Sequencer: decodes requests and steps the datapath through one frame.
// ----------------------------------------------------------------------------
module sfc_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [sfc_pkg::REQ_W-1:0] s_req_type,
    output sfc_pkg::sfc_cmd_t              cmd,
    input  wire sfc_pkg::sfc_sts_t         sts
);
    import sfc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_req_type)
                        REQ_FRAME: begin
                            cmd.frame_start = 1'b1;
                            state_next      = ST_ISSUE;
                        end
                        REQ_COEFF: cmd.coeff_wr   = 1'b1;
                        REQ_CLEAR: cmd.hist_clear = 1'b1;
                        default: ; // drop unknown request
                    endcase
                end
            end
            ST_ISSUE: begin
                cmd.tap_issue = 1'b1;
                if (sts.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sts.pipe_idle) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (sts.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/sfc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_datapath
// Coefficient and history memories, tap counters, two MAC lanes, output
// register and configuration registers.
// ----------------------------------------------------------------------------
module sfc_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire sfc_pkg::sfc_cmd_t                    cmd,
    output sfc_pkg::sfc_sts_t                         sts,
    input  wire logic signed [sfc_pkg::SAMPLE_BITS-1:0] s_left_sample,
    input  wire logic signed [sfc_pkg::SAMPLE_BITS-1:0] s_right_sample,
    input  wire logic [sfc_pkg::IDX_W-1:0]            s_coeff_index,
    input  wire logic signed [sfc_pkg::SAMPLE_BITS-1:0] s_coeff_value,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [sfc_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [sfc_pkg::SAMPLE_BITS-1:0]    m_left_out,
    output logic signed [sfc_pkg::SAMPLE_BITS-1:0]    m_right_out
);
    import sfc_pkg::*;

    // Configuration
    logic [TAP_CFG_W-1:0]  tap_reg;
    logic [CHAN_CFG_W-1:0] chan_reg;
    logic [CNT_W-1:0]      active_taps;
    logic                  stereo;

    // Frame bookkeeping
    logic [ADDR_W-1:0] pos_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [ADDR_W-1:0] slot_reg;

    // Pipeline
    logic                          v1_reg;
    logic                          ok1_reg;
    logic                          v2_reg;
    logic signed [SAMPLE_BITS-1:0] coef_rd;
    logic signed [SAMPLE_BITS-1:0] left_rd;
    logic signed [SAMPLE_BITS-1:0] right_rd;
    logic signed [SAMPLE_BITS-1:0] right_wr;
    logic signed [PROD_W-1:0]      prod_l_full;
    logic signed [PROD_W-1:0]      prod_r_full;
    logic signed [PROD_W-1:0]      prod_l_reg;
    logic signed [PROD_W-1:0]      prod_r_reg;
    logic signed [ACC_W-1:0]       acc_l_reg;
    logic signed [ACC_W-1:0]       acc_r_reg;
    logic                          coeff_in_range;

    // Output register
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    always_comb begin
        if (tap_reg == '0) begin
            active_taps = CNT_W'(1);
        end else if (32'(tap_reg) > MAX_TAPS) begin
            active_taps = CNT_W'(MAX_TAPS);
        end else begin
            active_taps = CNT_W'(tap_reg);
        end
    end

    assign stereo         = (chan_reg >= CHAN_CFG_W'(2));
    assign right_wr       = stereo ? s_right_sample : '0;
    assign coeff_in_range = (32'(s_coeff_index) < MAX_TAPS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_reg  <= TAP_CFG_W'(1);
            chan_reg <= CHAN_CFG_W'(2);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TAP_COUNT:     tap_reg  <= cfg_wr_data[TAP_CFG_W-1:0];
                REG_CHANNEL_COUNT: chan_reg <= cfg_wr_data[CHAN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Memories
    sfc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_coeff_ram (
        .aclk    (aclk),
        .wr_en   (cmd.coeff_wr && coeff_in_range),
        .wr_addr (ADDR_W'(s_coeff_index)),
        .wr_data (s_coeff_value),
        .rd_addr (k_reg[ADDR_W-1:0]),
        .rd_data (coef_rd)
    );

    sfc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_left_ram (
        .aclk    (aclk),
        .wr_en   (cmd.frame_start),
        .wr_addr (pos_reg),
        .wr_data (s_left_sample),
        .rd_addr (slot_reg),
        .rd_data (left_rd)
    );

    sfc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_right_ram (
        .aclk    (aclk),
        .wr_en   (cmd.frame_start),
        .wr_addr (pos_reg),
        .wr_data (right_wr),
        .rd_addr (slot_reg),
        .rd_data (right_rd)
    );

    // Position, fill count and tap counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            fill_reg <= '0;
            k_reg    <= '0;
            slot_reg <= '0;
        end else if (cmd.hist_clear) begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end else if (cmd.frame_start) begin
            k_reg    <= '0;
            slot_reg <= pos_reg;
            pos_reg  <= (pos_reg == ADDR_W'(MAX_TAPS - 1)) ? '0 : pos_reg + 1'b1;
            if (fill_reg != CNT_W'(MAX_TAPS)) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end else if (cmd.tap_issue) begin
            k_reg    <= k_reg + 1'b1;
            slot_reg <= (slot_reg == '0) ? ADDR_W'(MAX_TAPS - 1) : slot_reg - 1'b1;
        end
    end

    // MAC pipeline: read, multiply, accumulate
    assign prod_l_full = coef_rd * left_rd;
    assign prod_r_full = coef_rd * right_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.tap_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ok1_reg    <= (k_reg < fill_reg);
        // Zero history slots not written since the last clear
        prod_l_reg <= ok1_reg ? prod_l_full : '0;
        prod_r_reg <= (ok1_reg && stereo) ? prod_r_full : '0;
        if (cmd.frame_start) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (v2_reg) begin
            acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            left_out_reg  <= round_sat(acc_l_reg);
            right_out_reg <= stereo ? round_sat(acc_r_reg) : '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = left_out_reg;
    assign m_right_out = right_out_reg;

    assign sts.last_tap  = (k_reg == active_taps - 1'b1);
    assign sts.pipe_idle = !v1_reg && !v2_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    // Checks
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending result");

    a_start_on_empty_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.frame_start |-> (!v1_reg && !v2_reg))
        else $error("frame started with taps still in flight");

    a_load_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> (!v1_reg && !v2_reg && !cmd.tap_issue))
        else $error("result loaded before accumulation finished");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(MAX_TAPS))
        else $error("fill count beyond history depth");

endmodule
`default_nettype wire

@@ hdl/stereo_fir_convolver_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Stereo FIR convolver: each sample frame yields one output frame that is,
// per channel, the sum over the active taps of coefficient k times the
// sample k frames back, rounded to nearest (ties up) and saturated to 24
// bits; mono gives a zero right output. The active tap count (tap_count)
// is held to 1..4096. A frame occupies the block until its result is loaded
// into the output register, and that waits while an earlier result is still
// pending there. The frame time is set by the single multiply-accumulate
// pass that reads one tap per cycle from the coefficient and history
// memories. Coefficient writes and history clears produce no output.
// History clears are handled by a fill count, so there is no clearing pass
// after reset or after a clear.
// ----------------------------------------------------------------------------
// stereo_fir_convolver_core
// Top level: request sequencer plus MAC datapath with tap and history memories.
// ----------------------------------------------------------------------------
module stereo_fir_convolver_core (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Request channel
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [sfc_pkg::REQ_W-1:0]              s_req_type,
    input  wire logic signed [sfc_pkg::SAMPLE_BITS-1:0] s_left_sample,
    input  wire logic signed [sfc_pkg::SAMPLE_BITS-1:0] s_right_sample,
    input  wire logic [sfc_pkg::IDX_W-1:0]              s_coeff_index,
    input  wire logic signed [sfc_pkg::SAMPLE_BITS-1:0] s_coeff_value,
    // Configuration write port
    input  wire logic                                   cfg_wr_en,
    input  wire logic [sfc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [sfc_pkg::CFG_DATA_W-1:0]         cfg_wr_data,
    // Result channel
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [sfc_pkg::SAMPLE_BITS-1:0]      m_left_out,
    output logic signed [sfc_pkg::SAMPLE_BITS-1:0]      m_right_out
);
    import sfc_pkg::*;

    sfc_cmd_t cmd;
    sfc_sts_t sts;

    // Sequencer: accept a transaction only when idle, then walk the taps,
    // wait for the MAC pipe to drain, and hand the result to the output
    // register once it is free.
    sfc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Datapath: memories, counters, multiply-accumulate lanes and the output
    // register. The output register holds a finished frame until taken, so
    // the next transaction can be accepted while the previous result waits.
    sfc_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .s_coeff_index  (s_coeff_index),
        .s_coeff_value  (s_coeff_value),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out)
    );

endmodule
`default_nettype wire
